// ===== rtl/spds_pkg.sv =====
package spds_pkg;

  // how the front part classifies one point
  typedef enum logic [1:0] {
    KIND_FIRST = 2'd0,  // first point of a scan, or first point after reset
    KIND_JOIN  = 2'd1,  // close enough to the previous point
    KIND_BREAK = 2'd2   // opens the next cluster
  } kind_e;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENSOR_X   = 3'd0,
    REG_SENSOR_Y   = 3'd1,
    REG_SENSOR_Z   = 3'd2,
    REG_NEAR_THR   = 3'd3,
    REG_FAR_RANGE  = 3'd4,
    REG_RANGE_GAIN = 3'd5
  } cfg_reg_e;

  localparam int NEAR_W = 16;
  localparam int FAR_W  = 23;
  localparam int GAIN_W = 16;

  localparam logic [NEAR_W-1:0] NEAR_RESET = 16'd205;
  localparam logic [FAR_W-1:0]  FAR_RESET  = 23'd23552;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd572;

  // entries of the queue between front and back
  localparam int QUEUE_DEPTH = 8;

endpackage

// ===== rtl/spds_front.sv =====
module spds_front #(
  parameter int COORD_BITS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic signed [COORD_BITS-1:0]     point_x_i,
  input  logic signed [COORD_BITS-1:0]     point_y_i,
  input  logic                             scan_start_i,
  input  logic signed [COORD_BITS-1:0]     sensor_x_i,
  input  logic signed [COORD_BITS-1:0]     sensor_y_i,
  input  logic signed [COORD_BITS-1:0]     sensor_z_i,
  input  logic [spds_pkg::NEAR_W-1:0]      near_i,
  input  logic [spds_pkg::FAR_W-1:0]       far_i,
  input  logic [spds_pkg::GAIN_W-1:0]      gain_i,
  output logic                             valid_o,
  output spds_pkg::kind_e                  kind_o
);

  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int SUM_W   = SQ_W + 1;
  localparam int NEAR2_W = 2 * spds_pkg::NEAR_W;
  localparam int FAR2_W  = 2 * spds_pkg::FAR_W;
  localparam int G2_W    = 2 * spds_pkg::GAIN_W;
  localparam int R2P_W   = (SUM_W > G2_W) ? SUM_W : G2_W + 1;
  localparam int HI_W    = R2P_W - G2_W;
  localparam int CMP_W   = R2P_W + G2_W;
  localparam int NC_W    = (SUM_W > NEAR2_W) ? SUM_W : NEAR2_W;
  localparam int FC_W    = (SUM_W > FAR2_W) ? SUM_W : FAR2_W;

  function automatic logic [DIFF_W-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                  input logic [COORD_BITS-1:0] b);
    logic [DIFF_W-1:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    return d[DIFF_W-1] ? (~d + 1'b1) : d;
  endfunction

  // accept side
  logic                  seen_q;
  logic [COORD_BITS-1:0] prev_x_q, prev_y_q;

  // stage a: absolute differences
  logic              a_v_q, a_first_q, a_zero_q;
  logic [DIFF_W-1:0] a_dx_q, a_dy_q, a_rx_q, a_ry_q;

  // stage b: squares
  logic               b_v_q, b_first_q, b_zero_q;
  logic [SQ_W-1:0]    b_dx2_q, b_dy2_q, b_rx2_q, b_ry2_q;
  logic [NEAR2_W-1:0] b_near2_q;
  logic [FAR2_W-1:0]  b_far2_q;
  logic [G2_W-1:0]    b_g2_q;

  // stage c: sums of squares
  logic               c_v_q, c_first_q, c_zero_q;
  logic [SUM_W-1:0]   c_d2_q, c_r2_q;
  logic [NEAR2_W-1:0] c_near2_q;
  logic [FAR2_W-1:0]  c_far2_q;
  logic [G2_W-1:0]    c_g2_q;

  // stage d: compares and partial products of gain^2 * r^2
  logic                  d_v_q, d_first_q, d_zero_q, d_near_ok_q, d_inside_q;
  logic [SUM_W-1:0]      d_d2_q;
  logic [2*G2_W-1:0]     d_pp_lo_q;
  logic [HI_W+G2_W-1:0]  d_pp_hi_q;

  logic [R2P_W-1:0] c_r2p;
  logic [CMP_W-1:0] lhs, rhs;
  logic             far_ok, joins;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= 1'b0;
      prev_x_q <= '0;
      prev_y_q <= '0;
    end else if (valid_i) begin
      seen_q   <= 1'b1;
      prev_x_q <= point_x_i;
      prev_y_q <= point_y_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else begin
      a_v_q <= valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_first_q <= scan_start_i | ~seen_q;
    a_zero_q  <= (sensor_x_i == '0) && (sensor_y_i == '0) && (sensor_z_i == '0);
    a_dx_q    <= abs_diff(point_x_i, prev_x_q);
    a_dy_q    <= abs_diff(point_y_i, prev_y_q);
    a_rx_q    <= abs_diff(point_x_i, sensor_x_i);
    a_ry_q    <= abs_diff(point_y_i, sensor_y_i);

    b_first_q <= a_first_q;
    b_zero_q  <= a_zero_q;
    b_dx2_q   <= a_dx_q * a_dx_q;
    b_dy2_q   <= a_dy_q * a_dy_q;
    b_rx2_q   <= a_rx_q * a_rx_q;
    b_ry2_q   <= a_ry_q * a_ry_q;
    b_near2_q <= near_i * near_i;
    b_far2_q  <= far_i * far_i;
    b_g2_q    <= gain_i * gain_i;

    c_first_q <= b_first_q;
    c_zero_q  <= b_zero_q;
    c_d2_q    <= SUM_W'(b_dx2_q) + SUM_W'(b_dy2_q);
    c_r2_q    <= SUM_W'(b_rx2_q) + SUM_W'(b_ry2_q);
    c_near2_q <= b_near2_q;
    c_far2_q  <= b_far2_q;
    c_g2_q    <= b_g2_q;

    d_first_q   <= c_first_q;
    d_zero_q    <= c_zero_q;
    d_d2_q      <= c_d2_q;
    d_near_ok_q <= NC_W'(c_d2_q) < NC_W'(c_near2_q);
    d_inside_q  <= FC_W'(c_r2_q) < FC_W'(c_far2_q);
    d_pp_lo_q   <= c_r2p[G2_W-1:0] * c_g2_q;
    d_pp_hi_q   <= c_r2p[R2P_W-1:G2_W] * c_g2_q;
  end

  assign c_r2p = R2P_W'(c_r2_q);

  // d^2 * 2^32 < gain^2 * r^2
  assign lhs    = CMP_W'({d_d2_q, {G2_W{1'b0}}});
  assign rhs    = CMP_W'({d_pp_hi_q, {G2_W{1'b0}}}) + CMP_W'(d_pp_lo_q);
  assign far_ok = lhs < rhs;
  assign joins  = (d_zero_q || d_inside_q) ? d_near_ok_q : far_ok;

  always_comb begin
    priority if (d_first_q) begin
      kind_o = spds_pkg::KIND_FIRST;
    end else if (joins) begin
      kind_o = spds_pkg::KIND_JOIN;
    end else begin
      kind_o = spds_pkg::KIND_BREAK;
    end
  end

  assign valid_o = d_v_q;

endmodule

// ===== rtl/spds_queue.sv =====
module spds_queue #(
  parameter int DEPTH = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  spds_pkg::kind_e data_i,
  input  logic            pop_i,
  output spds_pkg::kind_e data_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  spds_pkg::kind_e  mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  assign wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
  assign rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
  assign count_d  = count_q + CNT_W'(do_push) - CNT_W'(do_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_d;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_d;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNT_W'(DEPTH));

endmodule

// ===== rtl/spds_back.sv =====
module spds_back #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  spds_pkg::kind_e                  kind_i,
  output logic                             take_o,
  input  logic                             out_pop_i,
  output logic                             out_valid_o,
  output logic [$clog2(MAX_POINTS+1)-1:0]  cluster_label_o,
  output logic                             opens_cluster_o,
  output logic [$clog2(MAX_POINTS+1)-1:0]  member_count_o,
  output logic [$clog2(MAX_POINTS)-1:0]    point_index_o
);

  localparam int LBL_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = $clog2(MAX_POINTS);

  logic [LBL_W-1:0] label_q, label_d, size_q, size_d;
  logic [IDX_W-1:0] next_idx_q, next_idx_d, idx_q, idx_d;
  logic             opens_q, opens_d, out_v_q;

  assign take_o = valid_i && (!out_v_q || out_pop_i);

  always_comb begin
    label_d = label_q;
    size_d  = size_q;
    idx_d   = next_idx_q;
    opens_d = 1'b1;
    unique case (kind_i)
      spds_pkg::KIND_FIRST: begin
        label_d = LBL_W'(1);
        size_d  = LBL_W'(1);
        idx_d   = '0;
      end
      spds_pkg::KIND_JOIN: begin
        size_d  = (size_q < LBL_W'(MAX_POINTS)) ? size_q + 1'b1 : size_q;
        opens_d = 1'b0;
      end
      spds_pkg::KIND_BREAK: begin
        label_d = (label_q < LBL_W'(MAX_POINTS)) ? label_q + 1'b1 : label_q;
        size_d  = LBL_W'(1);
      end
      default: begin
        label_d = label_q;
      end
    endcase
    next_idx_d = (idx_d < IDX_W'(MAX_POINTS - 1)) ? idx_d + 1'b1 : idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_q    <= '0;
      size_q     <= '0;
      next_idx_q <= '0;
      out_v_q    <= 1'b0;
    end else begin
      if (take_o) begin
        label_q    <= label_d;
        size_q     <= size_d;
        next_idx_q <= next_idx_d;
        out_v_q    <= 1'b1;
      end else if (out_pop_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      idx_q   <= idx_d;
      opens_q <= opens_d;
    end
  end

  assign out_valid_o     = out_v_q;
  assign cluster_label_o = label_q;
  assign member_count_o  = size_q;
  assign point_index_o   = idx_q;
  assign opens_cluster_o = opens_q;

endmodule

// ===== rtl/scan_point_distance_segmenter.sv =====
// scan point distance segmenter
// input channel: a point (point_x_i, point_y_i, scan_start_i) is taken on a clock edge
// with push high and full low. result channel: while empty is low the oldest result
// (cluster_label_o, opens_cluster_o, member_count_o, point_index_o) is on the ports and
// it leaves on an edge with pop high.
// configuration: cfg_we_i writes cfg_data_i into the register cfg_idx_i at the edge;
// write only while no point is in flight.
// throughput: one point per cycle as long as pop keeps up; the credit count over the
// four front stages and the eight-entry queue bounds the points in flight.
// path: an accepted point runs through the four front stages and the queue into the
// back output register; empty goes low once that register is loaded.
// reset: clears the queue, the counters and the previous point; config registers take
// their reset values and the first point after reset opens cluster 1.
// stall: when pop stays low the output register holds, the queue fills and full rises
// once the credits are used up; nothing is dropped and the front never stalls.
module scan_point_distance_segmenter #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 24
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // point channel
  input  logic                                   push,
  output logic                                   full,
  input  logic signed [COORD_BITS-1:0]           point_x_i,
  input  logic signed [COORD_BITS-1:0]           point_y_i,
  input  logic                                   scan_start_i,
  // result channel
  output logic                                   empty,
  input  logic                                   pop,
  output logic [$clog2(MAX_POINTS+1)-1:0]        cluster_label_o,
  output logic                                   opens_cluster_o,
  output logic [$clog2(MAX_POINTS+1)-1:0]        member_count_o,
  output logic [$clog2(MAX_POINTS)-1:0]          point_index_o,
  // configuration writes
  input  logic                                   cfg_we_i,
  input  logic [spds_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [((COORD_BITS > spds_pkg::FAR_W) ? COORD_BITS : spds_pkg::FAR_W)-1:0]
                                                 cfg_data_i
);

  localparam int LBL_W  = $clog2(MAX_POINTS + 1);
  localparam int CRED_W = $clog2(spds_pkg::QUEUE_DEPTH + 1);

  // configuration registers
  logic signed [COORD_BITS-1:0]    sensor_x_q, sensor_y_q, sensor_z_q;
  logic [spds_pkg::NEAR_W-1:0]     near_q;
  logic [spds_pkg::FAR_W-1:0]      far_q;
  logic [spds_pkg::GAIN_W-1:0]     gain_q;

  // front to queue to back
  logic            accept;
  logic            front_v;
  spds_pkg::kind_e front_kind, q_kind;
  logic            q_empty, q_full, take;
  logic            out_valid;

  // every accepted point holds a credit until the back takes it off the queue,
  // so the queue can never overflow while the front runs without stalls
  logic [CRED_W-1:0] credit_q, credit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_x_q <= '0;
      sensor_y_q <= '0;
      sensor_z_q <= '0;
      near_q     <= spds_pkg::NEAR_RESET;
      far_q      <= spds_pkg::FAR_RESET;
      gain_q     <= spds_pkg::GAIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        spds_pkg::REG_SENSOR_X:   sensor_x_q <= cfg_data_i[COORD_BITS-1:0];
        spds_pkg::REG_SENSOR_Y:   sensor_y_q <= cfg_data_i[COORD_BITS-1:0];
        spds_pkg::REG_SENSOR_Z:   sensor_z_q <= cfg_data_i[COORD_BITS-1:0];
        spds_pkg::REG_NEAR_THR:   near_q     <= cfg_data_i[spds_pkg::NEAR_W-1:0];
        spds_pkg::REG_FAR_RANGE:  far_q      <= cfg_data_i[spds_pkg::FAR_W-1:0];
        spds_pkg::REG_RANGE_GAIN: gain_q     <= cfg_data_i[spds_pkg::GAIN_W-1:0];
        default:                  near_q     <= near_q;  // unmapped index, ignored
      endcase
    end
  end

  assign full   = (credit_q == CRED_W'(spds_pkg::QUEUE_DEPTH));
  assign accept = push && !full;

  assign credit_d = credit_q + CRED_W'(accept) - CRED_W'(take);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      credit_q <= credit_d;
    end
  end

  // front: distance classification pipeline
  spds_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (accept),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .scan_start_i (scan_start_i),
    .sensor_x_i   (sensor_x_q),
    .sensor_y_i   (sensor_y_q),
    .sensor_z_i   (sensor_z_q),
    .near_i       (near_q),
    .far_i        (far_q),
    .gain_i       (gain_q),
    .valid_o      (front_v),
    .kind_o       (front_kind)
  );

  // decoupling queue of classified points
  spds_queue #(
    .DEPTH (spds_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_v),
    .data_i  (front_kind),
    .pop_i   (take),
    .data_o  (q_kind),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // back: label, size and index counters with the output register
  spds_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (!q_empty),
    .kind_i          (q_kind),
    .take_o          (take),
    .out_pop_i       (pop),
    .out_valid_o     (out_valid),
    .cluster_label_o (cluster_label_o),
    .opens_cluster_o (opens_cluster_o),
    .member_count_o  (member_count_o),
    .point_index_o   (point_index_o)
  );

  assign empty = !out_valid;

  // credits bound everything in flight by the queue depth
  a_credit_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q <= CRED_W'(spds_pkg::QUEUE_DEPTH))
    else $error("credit count above queue depth");

  // the front never pushes into a full queue
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_v |-> !q_full)
    else $error("front pushed into a full queue");

  // a point with index zero always starts a cluster
  a_index_zero_opens : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && point_index_o == '0) |-> opens_cluster_o)
    else $error("index zero point does not open a cluster");

  // a point that opens a cluster is its only member so far
  a_open_size_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && opens_cluster_o) |-> (member_count_o == LBL_W'(1)))
    else $error("opening point with size other than one");

  // a held result stays put while the receiver stalls
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(cluster_label_o) && $stable(point_index_o)))
    else $error("result changed while stalled");

endmodule

// ===== tb/sv/scan_point_distance_segmenter_test.sv =====
`timescale 1ns / 100ps

module scan_point_distance_segmenter_test;

  localparam int COORD_W      = 24;
  localparam int CFG_W        = 24;
  localparam int LBL_W        = 11;
  localparam int IDX_W        = 10;
  localparam int SAT_COUNT    = 1024;
  localparam int DRAIN_CYCLES = 8;        // wait after the last expected result, as margin
  localparam int TAIL_CYCLES  = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 200000;
  localparam int SCAN_PHASES  = 10;
  localparam int PHASE_POINTS = 85;
  localparam int LONG_POINTS  = 1030;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [LBL_W-1:0] label;
    logic             opens;
    logic [LBL_W-1:0] size;
    logic [IDX_W-1:0] index;
  } seg_result_t;

  typedef enum logic {ROW_POINT, ROW_WRITE} row_kind_e;

  // one line of the directed table; a write row carries its data in x
  typedef struct packed {
    row_kind_e          kind;
    spds_pkg::cfg_reg_e reg_sel;
    coord_t             x;
    coord_t             y;
    logic               start;
    logic               typed;
    seg_result_t        want;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;
  logic push;
  logic full;
  coord_t point_x_i;
  coord_t point_y_i;
  logic scan_start_i;
  logic empty;
  logic pop;
  logic [LBL_W-1:0] cluster_label_o;
  logic opens_cluster_o;
  logic [LBL_W-1:0] member_count_o;
  logic [IDX_W-1:0] point_index_o;
  logic cfg_we_i;
  logic [spds_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  scan_point_distance_segmenter u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .scan_start_i    (scan_start_i),
    .empty           (empty),
    .pop             (pop),
    .cluster_label_o (cluster_label_o),
    .opens_cluster_o (opens_cluster_o),
    .member_count_o  (member_count_o),
    .point_index_o   (point_index_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  // 2 ns clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow copy of the configuration registers
  coord_t                      sens_x, sens_y, sens_z;
  logic [spds_pkg::NEAR_W-1:0] near_thr;
  logic [spds_pkg::FAR_W-1:0]  far_rng;
  logic [spds_pkg::GAIN_W-1:0] gain_q16;

  // shadow copy of the segmentation state
  coord_t      last_x, last_y;
  int unsigned run_label, run_size, next_pos;

  seg_result_t pending_results[$];
  plan_row_t   plan[$];

  // idle percentages of each side, switched at phases 4 and 8
  int send_gap_pct;
  int recv_gap_pct;
  logic hold_go;
  logic hold_on;

  int cycle_count;
  int n_errors, n_points, n_scans, n_settings, n_results, n_joined, n_opened;

  // squared euclidean distance, exact in 128 bits
  function automatic logic [127:0] sq_dist(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    longint dx, dy;
    logic [127:0] ux, uy;
    dx = ax - bx;
    dy = ay - by;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    ux = dx;
    uy = dy;
    return ux * ux + uy * uy;
  endfunction

  // does the point stay in the running cluster
  function automatic bit closer_than_threshold(coord_t px, coord_t py);
    logic [127:0] d2, r2, lim, g2;
    d2 = sq_dist(px, py, last_x, last_y);
    lim = near_thr;
    lim = lim * lim;
    // all-zero pose: fixed threshold only
    if (sens_x == 0 && sens_y == 0 && sens_z == 0) return d2 < lim;
    r2 = sq_dist(px, py, sens_x, sens_y);
    g2 = far_rng;
    if (r2 < g2 * g2) return d2 < lim;
    // proportional threshold: d^2 * 2^32 < gain^2 * r^2, range exactly far included
    g2 = gain_q16;
    g2 = g2 * g2;
    return (d2 << 32) < r2 * g2;
  endfunction

  function automatic seg_result_t segment_point(coord_t px, coord_t py, logic start);
    seg_result_t r;
    int unsigned pos;
    r = '0;
    if (start || run_label == 0) begin
      run_label = 1;
      run_size = 1;
      pos = 0;
      r.opens = 1'b1;
    end else begin
      pos = next_pos;
      if (closer_than_threshold(px, py)) begin
        if (run_size < SAT_COUNT) run_size++;
        r.opens = 1'b0;
      end else begin
        if (run_label < SAT_COUNT) run_label++;
        run_size = 1;
        r.opens = 1'b1;
      end
    end
    next_pos = (pos < SAT_COUNT - 1) ? pos + 1 : pos;
    last_x = px;
    last_y = py;
    r.label = LBL_W'(run_label);
    r.size = LBL_W'(run_size);
    r.index = IDX_W'(pos);
    return r;
  endfunction

  function automatic plan_row_t pt(coord_t x, coord_t y, logic s);
    plan_row_t r;
    r = '0;
    r.kind = ROW_POINT;
    r.x = x;
    r.y = y;
    r.start = s;
    return r;
  endfunction

  // point row with its result typed in
  function automatic plan_row_t ptx(coord_t x, coord_t y, logic s,
                                    int lbl, int op, int sz, int ix);
    plan_row_t r;
    r = pt(x, y, s);
    r.typed = 1'b1;
    r.want.label = LBL_W'(lbl);
    r.want.opens = op[0];
    r.want.size = LBL_W'(sz);
    r.want.index = IDX_W'(ix);
    return r;
  endfunction

  function automatic plan_row_t wr(spds_pkg::cfg_reg_e sel, int val);
    plan_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.reg_sel = sel;
    r.x = coord_t'(val);
    return r;
  endfunction

  // append one row at the end of the directed table
  function automatic void plan_add(plan_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  function automatic int rand_step();
    int s;
    s = $urandom_range(0, 17);
    return int'($urandom_range(0, 2 << s)) - (1 << s);
  endfunction

  // offset from the sensor over many scales so ranges fall both sides of far_range
  function automatic int rand_offset();
    int m;
    m = 1 << $urandom_range(4, 23);
    return $urandom_range(0, 1) ? int'($urandom_range(0, m)) : -int'($urandom_range(0, m));
  endfunction

  function automatic int rand_pose();
    return ($urandom_range(0, 99) < 35) ? 0 : int'($urandom);
  endfunction

  task automatic note_mismatch(string field, int want, int got);
    n_errors++;
    $error("%s: expected %0d, actual %0d", field, want, got);
  endtask

  // drop push and let everything in flight come out
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(spds_pkg::cfg_reg_e sel, logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= sel;
    cfg_data_i <= val;
    case (sel)
      spds_pkg::REG_SENSOR_X:   sens_x = val;
      spds_pkg::REG_SENSOR_Y:   sens_y = val;
      spds_pkg::REG_SENSOR_Z:   sens_z = val;
      spds_pkg::REG_NEAR_THR:   near_thr = val[spds_pkg::NEAR_W-1:0];
      spds_pkg::REG_FAR_RANGE:  far_rng = val[spds_pkg::FAR_W-1:0];
      spds_pkg::REG_RANGE_GAIN: gain_q16 = val[spds_pkg::GAIN_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_setting(int sx, int sy, int sz, int nt, int fr, int g);
    wait_idle();
    write_reg(spds_pkg::REG_SENSOR_X, CFG_W'(sx));
    write_reg(spds_pkg::REG_SENSOR_Y, CFG_W'(sy));
    write_reg(spds_pkg::REG_SENSOR_Z, CFG_W'(sz));
    write_reg(spds_pkg::REG_NEAR_THR, CFG_W'(nt));
    write_reg(spds_pkg::REG_FAR_RANGE, CFG_W'(fr));
    write_reg(spds_pkg::REG_RANGE_GAIN, CFG_W'(g));
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // offer one point beat and record what it should produce once taken
  task automatic send_point(coord_t px, coord_t py, logic start, logic typed,
                            seg_result_t want);
    seg_result_t pred;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    point_x_i <= px;
    point_y_i <= py;
    scan_start_i <= start;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pred = segment_point(px, py, start);
    pending_results.insert(pending_results.size(), typed ? want : pred);
    n_points++;
    if (start) n_scans++;
  endtask

  // scans walked in steps of many sizes, with some noise and stray scan starts
  task automatic run_scan_phase(int n_items);
    int cx, cy, left, roll;
    logic st;
    left = 0;
    cx = 0;
    cy = 0;
    repeat (n_items) begin
      st = 1'b0;
      roll = $urandom_range(0, 99);
      if (left == 0) begin
        st = 1'b1;
        left = $urandom_range(1, 60);
        cx = int'(sens_x) + rand_offset();
        cy = int'(sens_y) + rand_offset();
      end else if (roll < 8) begin
        cx = $urandom;
        cy = $urandom;
        st = $urandom_range(0, 1);
      end else begin
        if (roll < 11) st = 1'b1;
        cx += rand_step();
        cy += rand_step();
      end
      left--;
      send_point(coord_t'(cx), coord_t'(cy), st, 1'b0, '0);
    end
  endtask

  // one scan long enough to saturate the counters: wide spread breaks every
  // time at zero threshold, tight spread always joins at the widest threshold
  task automatic run_long_scan(bit wide, int n_items);
    int bx, by;
    bx = $urandom_range(0, 8000000) - 4000000;
    by = $urandom_range(0, 8000000) - 4000000;
    for (int i = 0; i < n_items; i++) begin
      if (wide)
        send_point(coord_t'($urandom), coord_t'($urandom), i == 0, 1'b0, '0);
      else
        send_point(coord_t'(bx + int'($urandom_range(0, 32000)) - 16000),
                   coord_t'(by + int'($urandom_range(0, 32000)) - 16000),
                   i == 0, 1'b0, '0);
    end
  endtask

  // result side: check every beat taken, then choose the next pop
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        seg_result_t got, want;
        got.label = cluster_label_o;
        got.opens = opens_cluster_o;
        got.size = member_count_o;
        got.index = point_index_o;
        n_results++;
        if (got.opens) n_opened++;
        else n_joined++;
        if (pending_results.size() == 0) begin
          n_errors++;
          $error("result beat with no point waiting: label %0d size %0d index %0d",
                 got.label, got.size, got.index);
        end else begin
          want = pending_results.pop_front();
          if (got.label !== want.label)
            note_mismatch("cluster_label", want.label, got.label);
          if (got.opens !== want.opens)
            note_mismatch("opens_cluster", want.opens, got.opens);
          if (got.size !== want.size)
            note_mismatch("member_count", want.size, got.size);
          if (got.index !== want.index)
            note_mismatch("point_index", want.index, got.index);
        end
      end
      pop <= !hold_on && ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  // long receiver hold-off so the queue fills and full rises
  initial begin
    hold_on <= 1'b0;
    wait (hold_go);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    push <= 1'b0;
    point_x_i <= '0;
    point_y_i <= '0;
    scan_start_i <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= spds_pkg::REG_SENSOR_X;
    cfg_data_i <= '0;
    hold_go = 1'b0;
    n_errors = 0;
    n_points = 0;
    n_scans = 0;
    n_settings = 0;
    n_results = 0;
    n_joined = 0;
    n_opened = 0;
    // state after reset
    sens_x = '0;
    sens_y = '0;
    sens_z = '0;
    near_thr = spds_pkg::NEAR_RESET;
    far_rng = spds_pkg::FAR_RESET;
    gain_q16 = spds_pkg::GAIN_RESET;
    last_x = '0;
    last_y = '0;
    run_label = 0;
    run_size = 0;
    next_pos = 0;
    // sender light, receiver heavy idling first
    send_gap_pct = 16;
    recv_gap_pct = 79;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part on reset settings: pose zero, fixed threshold 205
    plan_add(ptx(0, 0, 0, 1, 1, 1, 0));            // first point after reset
    plan_add(ptx(100, 0, 0, 1, 0, 2, 1));
    plan_add(ptx(305, 0, 0, 2, 1, 1, 2));          // distance equal to threshold breaks
    plan_add(ptx(509, 0, 0, 2, 0, 2, 3));
    plan_add(ptx(8388607, 8388607, 0, 3, 1, 1, 4));
    plan_add(ptx(-8388608, -8388608, 0, 4, 1, 1, 5));
    plan_add(ptx(-8388608, -8388608, 1, 1, 1, 1, 0));
    plan_add(ptx(8388607, -8388608, 0, 2, 1, 1, 1));
    plan_add(ptx(8388607, -8388608, 0, 2, 0, 2, 2));
    // sensor off origin: range exactly far_range takes the proportional threshold
    plan_add(wr(spds_pkg::REG_SENSOR_X, 1));
    plan_add(ptx(23553, 205, 1, 1, 1, 1, 0));
    plan_add(pt(23553, 0, 0));
    plan_add(pt(23553, -206, 0));
    // zero threshold opens a cluster on every point
    plan_add(wr(spds_pkg::REG_NEAR_THR, 0));
    plan_add(wr(spds_pkg::REG_SENSOR_X, 0));
    plan_add(ptx(5, 5, 1, 1, 1, 1, 0));
    plan_add(ptx(5, 5, 0, 2, 1, 1, 1));
    // only z off zero still counts as a real pose; gain applies from range zero
    plan_add(wr(spds_pkg::REG_SENSOR_Z, 1));
    plan_add(wr(spds_pkg::REG_FAR_RANGE, 0));
    plan_add(wr(spds_pkg::REG_RANGE_GAIN, 65535));
    plan_add(pt(5, 5, 0));
    plan_add(pt(-8388608, 8388607, 0));
    plan_add(wr(spds_pkg::REG_RANGE_GAIN, 0));
    plan_add(pt(-8388608, 8388607, 0));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(plan[i].reg_sel, plan[i].x);
        cfg_we_i <= 1'b0;
        n_settings++;
      end else begin
        send_point(plan[i].x, plan[i].y, plan[i].start, plan[i].typed, plan[i].want);
      end
    end

    // random part, one register setting per phase
    for (int p = 0; p < SCAN_PHASES; p++) begin
      if (p == 4) begin
        send_gap_pct = 79;
        recv_gap_pct = 16;
      end else if (p == 8) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      case (p)
        0: apply_setting(0, 0, 0, spds_pkg::NEAR_RESET, spds_pkg::FAR_RESET,
                         spds_pkg::GAIN_RESET);
        1: apply_setting(8388607, 8388607, 8388607, 65535, 8388607, 65535);
        2: apply_setting(-8388608, -8388608, -8388608, 0, 0, 0);
        default:
          apply_setting(rand_pose(), rand_pose(), rand_pose(),
                        ($urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(0, 65535)),
                        $urandom_range(0, 1 << $urandom_range(0, 23)) & 32'h7F_FFFF,
                        $urandom_range(0, 65535));
      endcase
      if (p == 8) hold_go = 1'b1;
      run_scan_phase(PHASE_POINTS);
    end

    // label and index saturation
    apply_setting(0, 0, 0, 0, spds_pkg::FAR_RESET, spds_pkg::GAIN_RESET);
    run_long_scan(1'b1, LONG_POINTS);

    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      n_errors += pending_results.size();
      $error("%0d expected results never arrived", pending_results.size());
    end

    $display("covered %0d points in %0d scans over %0d register settings, with a long stall",
             n_points, n_scans, n_settings);
    $display("%0d results checked: %0d joined, %0d opened a cluster; %0d errors",
             n_results, n_joined, n_opened, n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
